### src/gbts_pkg.sv
// Package: shared widths, default capacity, command and status codes for the gap buffer store.
`default_nettype none
package gbts_pkg;
	localparam int CAPACITY_DEF = 1024;
	localparam int CMD_W        = 2;
	localparam int POS_W        = 11;
	localparam int DATA_W       = 8;
	localparam int STAT_W       = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
endpackage
`default_nettype wire

### src/gap_buffer_text_store.sv
// Error items finish from idle without raising busy; reads go through a read state; inserts
// and deletes move the gap one byte per cycle through the single memory, then edit at it.
// busy is high while a valid item is in flight; a new item may start in the cycle done is high.
// done strobes for one cycle per item; the receiver cannot stall.
// Reset empties the text (gap spans the whole store); store contents stay undefined, no clear.
`default_nettype none
module gap_buffer_text_store #(
	parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [gbts_pkg::CMD_W-1:0]  cmd,
	input  wire logic [gbts_pkg::POS_W-1:0]  position,
	input  wire logic [gbts_pkg::DATA_W-1:0] char_in,
	output logic                             done,
	output logic      [gbts_pkg::POS_W-1:0]  new_position,
	output logic      [gbts_pkg::DATA_W-1:0] char_out,
	output logic      [gbts_pkg::POS_W-1:0]  text_length,
	output logic      [gbts_pkg::STAT_W-1:0] status
);
	import gbts_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int PW = $clog2(CAPACITY + 1);
	localparam int CW = (PW > POS_W) ? PW : POS_W;
	localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MOVE = 2'd1;
	localparam logic [1:0] S_OP   = 2'd2;
	localparam logic [1:0] S_RD   = 2'd3;

	logic [1:0]        state_q;
	logic [PW-1:0]     gs_q, ge_q;
	logic              done_q;
	logic              cp_wr_s1;
	logic [AW-1:0]     cp_wa_s1;
	logic [CMD_W-1:0]  cmd_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] ch_q;
	logic [POS_W-1:0]  npos_q;
	logic [DATA_W-1:0] cout_q;
	logic [POS_W-1:0]  len_q;
	logic [STAT_W-1:0] stat_q;

	logic              accept;
	logic [PW-1:0]     gap_w, len_cur, gs_dec, ge_dec, gs_inc;
	logic [CW-1:0]     len_w, len_inc, len_dec, pos_in_w, pos_w, gs_w, rd_idx_w;
	logic              in_err;
	logic [STAT_W-1:0] in_stat;
	logic              mv_left, mv_right;
	logic              re, we;
	logic [AW-1:0]     ra, wa;
	logic [DATA_W-1:0] wd, rdata;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign gap_w    = ge_q - gs_q;
	assign len_cur  = CAP_P - gap_w;
	assign len_w    = CW'(len_cur);
	assign len_inc  = len_w + CW'(1);
	assign len_dec  = len_w - CW'(1);
	assign pos_in_w = CW'(position);
	assign pos_w    = CW'(pos_q);
	assign gs_w     = CW'(gs_q);
	assign gs_dec   = gs_q - PW'(1);
	assign gs_inc   = gs_q + PW'(1);
	assign ge_dec   = ge_q - PW'(1);
	assign rd_idx_w = (pos_in_w < gs_w) ? pos_in_w : (pos_in_w + CW'(gap_w));
	assign mv_left  = (pos_w < gs_w);
	assign mv_right = (pos_w > gs_w);

	always_comb begin
		in_stat = STAT_OK;
		case (cmd)
			CMD_INSERT: begin
				if (len_cur == CAP_P) begin
					in_stat = STAT_FULL;
				end else if (pos_in_w > len_w) begin
					in_stat = STAT_RANGE;
				end
			end
			CMD_DELETE: begin
				if (pos_in_w == '0 || pos_in_w > len_w) begin
					in_stat = STAT_RANGE;
				end
			end
			CMD_READ: begin
				if (pos_in_w >= len_w) begin
					in_stat = STAT_RANGE;
				end
			end
			default: in_stat = STAT_RANGE;
		endcase
	end
	assign in_err = (in_stat != STAT_OK);

	// gap copies: read this cycle, write the returned byte next cycle
	assign re = (accept && cmd == CMD_READ && !in_err)
		|| (state_q == S_MOVE && (mv_left || mv_right));
	assign ra = (state_q == S_MOVE) ? (mv_left ? gs_dec[AW-1:0] : ge_q[AW-1:0])
		: rd_idx_w[AW-1:0];
	assign we = cp_wr_s1 || (state_q == S_OP && cmd_q == CMD_INSERT);
	assign wa = cp_wr_s1 ? cp_wa_s1 : gs_q[AW-1:0];
	assign wd = cp_wr_s1 ? rdata : ch_q;

	gbts_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.wa   (wa),
		.wd   (wd),
		.re   (re),
		.ra   (ra),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			gs_q     <= '0;
			ge_q     <= CAP_P;
			done_q   <= 1'b0;
			cp_wr_s1 <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			cp_wr_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_err) begin
							done_q <= 1'b1;
						end else if (cmd == CMD_READ) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_MOVE;
						end
					end
				end
				S_MOVE: begin
					if (mv_left) begin
						gs_q     <= gs_dec;
						ge_q     <= ge_dec;
						cp_wr_s1 <= 1'b1;
					end else if (mv_right) begin
						gs_q     <= gs_inc;
						ge_q     <= ge_q + PW'(1);
						cp_wr_s1 <= 1'b1;
					end else begin
						state_q <= S_OP;
					end
				end
				S_OP: begin
					gs_q    <= (cmd_q == CMD_INSERT) ? gs_inc : gs_dec;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RD: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q  <= cmd;
					pos_q  <= position;
					ch_q   <= char_in;
					npos_q <= position;
					cout_q <= '0;
					len_q  <= len_w[POS_W-1:0];
					stat_q <= in_stat;
				end
			end
			S_MOVE: begin
				cp_wa_s1 <= mv_left ? ge_dec[AW-1:0] : gs_q[AW-1:0];
			end
			S_OP: begin
				if (cmd_q == CMD_INSERT) begin
					npos_q <= pos_q + POS_W'(1);
					len_q  <= len_inc[POS_W-1:0];
				end else begin
					npos_q <= pos_q - POS_W'(1);
					len_q  <= len_dec[POS_W-1:0];
				end
			end
			S_RD: begin
				cout_q <= rdata;
			end
			default: begin
				cout_q <= cout_q;
			end
		endcase
	end

	assign done         = done_q;
	assign new_position = npos_q;
	assign char_out     = cout_q;
	assign text_length  = len_q;
	assign status       = stat_q;

	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		gs_q <= ge_q)
		else $error("gap start passed gap end");

	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OP) |-> !cp_wr_s1)
		else $error("copy write pending during insert/delete write");

	a_move_keeps_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |=> ((ge_q - gs_q) == $past(ge_q - gs_q)))
		else $error("gap width changed while moving");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_OP || state_q == S_RD || (start && !busy)))
		else $error("done without an item finishing");
endmodule
`default_nettype wire

### src/gbts_mem.sv
// Text byte store: one write port, one read port, registered read data.
`default_nettype none
module gbts_mem #(
	parameter int DEPTH = gbts_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               wa,
	input  wire logic [gbts_pkg::DATA_W-1:0] wd,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               ra,
	output logic      [gbts_pkg::DATA_W-1:0] rdata
);
	import gbts_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rdata_q <= mem[ra];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for gap_buffer_text_store: directed edits, random edits and long gap moves.
module tb_top;
	import gbts_pkg::*;

	localparam int CLK_HALF    = 10;
	localparam int STORE_CAP   = CAPACITY_DEF;
	localparam int STALL_LIMIT = 8 * (STORE_CAP + 16);

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0]  new_position;
		logic [DATA_W-1:0] char_out;
		logic [POS_W-1:0]  text_length;
		logic [STAT_W-1:0] status;
	} edit_result_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              start    = 1'b0;
	logic [CMD_W-1:0]  cmd      = '0;
	logic [POS_W-1:0]  position = '0;
	logic [DATA_W-1:0] char_in  = '0;
	logic              busy;
	logic              done;
	logic [POS_W-1:0]  new_position;
	logic [DATA_W-1:0] char_out;
	logic [POS_W-1:0]  text_length;
	logic [STAT_W-1:0] status;

	logic [DATA_W-1:0] text_model[$];
	edit_result_t      expected_results[$];
	int                mismatch_count = 0;
	int                stall_cycles   = 0;
	int                ops_sent[4]    = '{0, 0, 0, 0};
	int                status_seen[4] = '{0, 0, 0, 0};
	int                longest_text   = 0;
	bit                sender_idles   = 1'b1;

	gap_buffer_text_store #(
		.CAPACITY(STORE_CAP)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.position    (position),
		.char_in     (char_in),
		.done        (done),
		.new_position(new_position),
		.char_out    (char_out),
		.text_length (text_length),
		.status      (status)
	);

	always #CLK_HALF clk = ~clk;

	// Text kept as a plain byte queue; the gap location is invisible at the ports.
	function automatic edit_result_t apply_edit(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
			logic [DATA_W-1:0] ch);
		edit_result_t r;
		int unsigned  len;
		len = text_model.size();
		r.new_position = pos;
		r.char_out     = '0;
		r.status       = STAT_OK;
		case (op)
			CMD_INSERT: begin
				if (len >= STORE_CAP) begin
					r.status = STAT_FULL;
				end else if (pos > len) begin
					r.status = STAT_RANGE;
				end else begin
					text_model.insert(pos, ch);
					r.new_position = pos + 1'b1;
				end
			end
			CMD_DELETE: begin
				if (pos == 0 || pos > len) begin
					r.status = STAT_RANGE;
				end else begin
					text_model.delete(pos - 1);
					r.new_position = pos - 1'b1;
				end
			end
			CMD_READ: begin
				if (pos >= len) begin
					r.status = STAT_RANGE;
				end else begin
					r.char_out = text_model[pos];
				end
			end
			default: begin
				r.status = STAT_RANGE;
			end
		endcase
		r.text_length = POS_W'(text_model.size());
		if (text_model.size() > longest_text) longest_text = text_model.size();
		status_seen[r.status]++;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_item(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
			logic [DATA_W-1:0] ch);
		@(negedge clk);
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		start    <= 1'b1;
		cmd      <= op;
		position <= pos;
		char_in  <= ch;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.push_back(apply_edit(op, pos, ch));
		ops_sent[op]++;
	endtask

	always @(posedge clk) begin : check_results
		edit_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no item pending", new_position, 0);
			end else begin
				want = expected_results.pop_front();
				if (new_position !== want.new_position)
					report_mismatch("new_position", new_position, want.new_position);
				if (char_out !== want.char_out)
					report_mismatch("char_out", char_out, want.char_out);
				if (text_length !== want.text_length)
					report_mismatch("text_length", text_length, want.text_length);
				if (status !== want.status)
					report_mismatch("status", status, want.status);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("ERROR %0t: no progress for %0d cycles", $time, stall_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic test_empty_store_errors();
		send_item(CMD_READ, '0, 8'h00);
		send_item(CMD_DELETE, '0, 8'h00);
		send_item(CMD_DELETE, 11'd1, 8'h00);
		send_item(CMD_INSERT, 11'd1, 8'h3C);
		send_item(CMD_UNUSED, '0, 8'hFF);
		send_item(CMD_READ, '1, 8'hFF);
		send_item(CMD_INSERT, '1, 8'hFF);
	endtask

	task automatic test_basic_edits();
		send_item(CMD_INSERT, 11'd0, 8'h00);
		send_item(CMD_INSERT, 11'd1, 8'hFF);
		send_item(CMD_INSERT, 11'd0, 8'hA5);
		send_item(CMD_INSERT, 11'd2, 8'h5A);
		for (int i = 0; i < 5; i++) send_item(CMD_READ, POS_W'(i), 8'hFF);
		send_item(CMD_INSERT, 11'd5, 8'h11);
		send_item(CMD_DELETE, 11'd5, 8'h00);
		send_item(CMD_DELETE, 11'd4, 8'h00);
		send_item(CMD_DELETE, 11'd1, 8'h00);
		send_item(CMD_UNUSED, 11'd1, 8'hFF);
		send_item(CMD_DELETE, '1, 8'h00);
		send_item(CMD_READ, 11'd0, 8'h00);
		send_item(CMD_READ, 11'd1, 8'h00);
	endtask

	task automatic test_random_edits(int n_items);
		int unsigned      len;
		int unsigned      pick;
		int unsigned      pos;
		int unsigned      cursor;
		logic [CMD_W-1:0] op;
		cursor = 0;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 39) == 0) sender_idles = !sender_idles;
			len  = text_model.size();
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				send_item(CMD_W'($urandom), POS_W'($urandom), DATA_W'($urandom));
				continue;
			end
			if (pick < (len < 300 ? 55 : 40)) begin
				op = CMD_INSERT;
			end else if (pick < 80) begin
				op = CMD_DELETE;
			end else begin
				op = CMD_READ;
			end
			case ($urandom_range(0, 4))
				0, 1: pos = $urandom_range(0, len);
				2: pos = (cursor > 2 ? cursor - 2 : 0) + $urandom_range(0, 4);
				3: pos = len;
				default: pos = $urandom_range(0, 3);
			endcase
			if (pos > len) pos = len;
			if (op == CMD_READ && pos == len && len != 0 && $urandom_range(0, 3) != 0)
				pos = len - 1;
			send_item(op, POS_W'(pos), DATA_W'($urandom));
			cursor = pos;
		end
	endtask

	// edits that swing the gap between the two ends of the text
	task automatic test_long_moves();
		sender_idles = 1'b0;
		for (int i = 0; i < 12; i++) begin
			send_item(CMD_INSERT, POS_W'(text_model.size()), DATA_W'($urandom));
			send_item(CMD_INSERT, 11'd0, DATA_W'($urandom));
			send_item(CMD_DELETE, POS_W'(text_model.size()), 8'h00);
			send_item(CMD_DELETE, 11'd1, 8'h00);
			send_item(CMD_READ, POS_W'($urandom_range(0, text_model.size())), 8'h00);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_store_errors();
		test_basic_edits();
		test_random_edits(500);
		test_long_moves();
		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (STORE_CAP + 8) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("items left without result", expected_results.size(), 0);
		$display("Sent %0d inserts, %0d deletes, %0d reads, %0d unused commands; text peaked at %0d bytes",
			ops_sent[CMD_INSERT], ops_sent[CMD_DELETE], ops_sent[CMD_READ],
			ops_sent[CMD_UNUSED], longest_text);
		$display("Outcomes: %0d ok, %0d full, %0d out of range",
			status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_RANGE]);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
